[hw/rtl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// shared types, codes and helpers of the accumulator cpu step block
// ----------------------------------------------------------------------------
package acs_pkg;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_AND   = 3'd1,
        OP_OR    = 3'd2,
        OP_XOR   = 3'd3,
        OP_ADD   = 3'd4,
        OP_SUB   = 3'd5,
        OP_STORE = 3'd6,
        OP_JUMP  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        SRC_OPERAND = 2'd0,
        SRC_RAM     = 2'd1,
        SRC_ACC     = 2'd2,
        SRC_INPUT   = 2'd3
    } src_t;

    // addressing modes
    localparam logic [2:0] MODE_D_AC    = 3'd0;
    localparam logic [2:0] MODE_X_AC    = 3'd1;
    localparam logic [2:0] MODE_YD_AC   = 3'd2;
    localparam logic [2:0] MODE_YX_AC   = 3'd3;
    localparam logic [2:0] MODE_D_X     = 3'd4;
    localparam logic [2:0] MODE_D_Y     = 3'd5;
    localparam logic [2:0] MODE_D_OUT   = 3'd6;
    localparam logic [2:0] MODE_YXI_OUT = 3'd7;

    localparam logic [15:0] PAGE_MASK  = 16'hff00;
    localparam logic [7:0]  OUT_RESET  = 8'h80;
    localparam logic [16:0] ROM_WORDS_RESET = 17'h10000;

    typedef struct packed {
        logic [7:0]  instr;
        logic [7:0]  operand;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  outp;
    } cpu_state_t;

    typedef struct packed {
        logic [15:0] fetch_addr;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  outp;
    } result_t;

    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [7:0]  data;
    } ram_write_t;

    // full 16-bit data address of an instruction before masking to the ram size
    function automatic logic [15:0] data_addr(input logic [7:0] ir, input logic [7:0] d,
                                              input logic [7:0] x, input logic [7:0] y);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = 8'd0;
        lo = d;
        if (ir[7:5] != OP_JUMP) begin
            unique case (ir[4:2])
                MODE_X_AC:    lo = x;
                MODE_YD_AC:   hi = y;
                MODE_YX_AC,
                MODE_YXI_OUT: begin
                    lo = x;
                    hi = y;
                end
                default: ;
            endcase
        end
        return {hi, lo};
    endfunction

    function automatic logic [15:0] wrap_pc(input logic [15:0] p, input logic [16:0] words);
        return ({1'b0, p} >= words) ? 16'd0 : p;
    endfunction

endpackage

[hw/rtl/acs_exec.sv]
// ----------------------------------------------------------------------------
// acs_exec
// decode, alu and branch logic of one cpu cycle
// ----------------------------------------------------------------------------
module acs_exec
    import acs_pkg::*;
(
    input  cpu_state_t  cur,
    input  logic [16:0] rom_words,
    input  logic [7:0]  rom_opcode,
    input  logic [7:0]  rom_operand,
    input  logic [7:0]  input_port,
    input  logic [7:0]  bus_float,
    input  logic [7:0]  ram_rdata,
    output cpu_state_t  nxt,
    output ram_write_t  ram_wr,
    output logic [15:0] next_rd_addr,
    output result_t     result
);

    op_t        op;
    src_t       src;
    logic [2:0] mode;
    logic       is_store;
    logic       is_jump;
    logic [15:0] pc;
    logic [7:0] bus;
    logic [7:0] alu;
    logic [1:0] cond;
    logic       taken;
    logic [1:0] dest; // 0 none, 1 ac, 2 x, 3 y handled below with out flag
    logic       dest_out;

    always_comb begin
        op       = op_t'(cur.instr[7:5]);
        mode     = cur.instr[4:2];
        src      = src_t'(cur.instr[1:0]);
        is_store = (op == OP_STORE);
        is_jump  = (op == OP_JUMP);
        pc       = wrap_pc(cur.pc, rom_words);

        unique case (src)
            SRC_OPERAND: bus = cur.operand;
            SRC_RAM:     bus = is_store ? bus_float : ram_rdata;
            SRC_ACC:     bus = cur.acc;
            SRC_INPUT:   bus = input_port;
            default:     bus = cur.operand;
        endcase

        unique case (op)
            OP_LOAD: alu = bus;
            OP_AND:  alu = cur.acc & bus;
            OP_OR:   alu = cur.acc | bus;
            OP_XOR:  alu = cur.acc ^ bus;
            OP_ADD:  alu = cur.acc + bus;
            OP_SUB:  alu = cur.acc - bus;
            default: alu = cur.acc;
        endcase

        dest     = 2'd0;
        dest_out = 1'b0;
        if (!is_jump) begin
            unique case (mode)
                MODE_D_X:                dest = 2'd2;
                MODE_D_Y:                dest = 2'd3;
                MODE_D_OUT, MODE_YXI_OUT: dest_out = !is_store;
                default:                 dest = is_store ? 2'd0 : 2'd1;
            endcase
        end

        nxt         = cur;
        nxt.instr   = rom_opcode;
        nxt.operand = rom_operand;
        if (!is_jump && mode == MODE_YXI_OUT) begin
            nxt.x = cur.x + 8'd1;
        end
        unique case (dest)
            2'd1:    nxt.acc = alu;
            2'd2:    nxt.x   = alu;
            2'd3:    nxt.y   = alu;
            default: ;
        endcase
        if (dest_out) begin
            nxt.outp = alu;
        end

        // branch condition: ac > 0, ac < 0, ac == 0
        cond  = (cur.acc == 8'd0) ? 2'd2 : {1'b0, cur.acc[7]};
        taken = mode[cond];
        if (is_jump && mode == MODE_D_AC) begin
            nxt.pc = {nxt.y, bus};
        end else if (is_jump && taken) begin
            nxt.pc = (pc & PAGE_MASK) | {8'd0, bus};
        end else begin
            nxt.pc = pc + 16'd1;
        end

        ram_wr.en   = is_store;
        ram_wr.addr = data_addr(cur.instr, cur.operand, cur.x, cur.y);
        ram_wr.data = bus;

        next_rd_addr = data_addr(nxt.instr, nxt.operand, nxt.x, nxt.y);

        result.fetch_addr = wrap_pc(nxt.pc, rom_words);
        result.acc        = nxt.acc;
        result.x          = nxt.x;
        result.y          = nxt.y;
        result.outp       = nxt.outp;
    end

endmodule

[hw/rtl/accumulator_cpu_step_top.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_step_top
// one clock cycle of an 8-bit harvard accumulator cpu per request
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      rom_opcode, rom_operand, input_port, bus_float
//  m_        out        m_valid / m_ready      fetch_addr, acc_value, x_value, y_value,
//                                              output_port
//  cfg_      in         cfg_valid / cfg_ready  cfg_data = rom_words (17 bits)
//
//  one request per cycle while m_ready is high; each result is registered in the buffer
//  the data ram read for a request is issued at the edge that accepts the request
//  before it, so the single registered read port keeps up with every request
//  synchronous active-low reset sets state, config and valid flags; data ram is not cleared
//  a two-entry output buffer takes one more request during an m_ready stall; s_ready
//  then drops until the parked result moves up into the main slot on a take
//
module accumulator_cpu_step_top
    import acs_pkg::*;
#(
    parameter int RAM_ADDR_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rom_opcode,
    input  logic [7:0]  s_rom_operand,
    input  logic [7:0]  s_input_port,
    input  logic [7:0]  s_bus_float,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_fetch_addr,
    output logic [7:0]  m_acc_value,
    output logic [7:0]  m_x_value,
    output logic [7:0]  m_y_value,
    output logic [7:0]  m_output_port,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

    // architectural state
    cpu_state_t  state_reg;
    logic [16:0] rom_words_reg;

    // data ram with registered read
    logic [7:0]  ram [RAM_DEPTH];
    logic [7:0]  ram_rdata_reg;

    // output buffer: main slot plus skid slot
    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    cpu_state_t  state_next;
    ram_write_t  ram_wr;
    logic [15:0] rd_addr16;
    result_t     result;
    logic        accept;
    logic        take;
    logic [RAM_ADDR_BITS-1:0] wr_idx;
    logic [RAM_ADDR_BITS-1:0] rd_idx;

    acs_exec u_exec (
        .cur          (state_reg),
        .rom_words    (rom_words_reg),
        .rom_opcode   (s_rom_opcode),
        .rom_operand  (s_rom_operand),
        .input_port   (s_input_port),
        .bus_float    (s_bus_float),
        .ram_rdata    (ram_rdata_reg),
        .nxt          (state_next),
        .ram_wr       (ram_wr),
        .next_rd_addr (rd_addr16),
        .result       (result)
    );

    assign wr_idx    = ram_wr.addr[RAM_ADDR_BITS-1:0];
    assign rd_idx    = rd_addr16[RAM_ADDR_BITS-1:0];

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign take      = out_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_words_reg <= ROM_WORDS_RESET;
        end else if (cfg_valid) begin
            rom_words_reg <= cfg_data;
        end
    end

    // cpu registers advance once per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{outp: OUT_RESET, default: '0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // read-modify-write on the ram: the store of this request and the read for
    // the next one share the edge; a read of the byte being stored forwards it
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (ram_wr.en) begin
                ram[wr_idx] <= ram_wr.data;
            end
            if (ram_wr.en && wr_idx == rd_idx) begin
                ram_rdata_reg <= ram_wr.data;
            end else begin
                ram_rdata_reg <= ram[rd_idx];
            end
        end
    end

    // output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // skid drains into the main slot when the consumer takes
                if (take) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (out_valid_reg && !take) begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end else if (take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !take) begin
                skid_reg <= result;
            end else begin
                out_reg <= result;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fetch_addr  = out_reg.fetch_addr;
    assign m_acc_value   = out_reg.acc;
    assign m_x_value     = out_reg.x;
    assign m_y_value     = out_reg.y;
    assign m_output_port = out_reg.outp;

    // skid slot only fills behind a held main slot
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot valid without main slot");

    // every accepted request leaves a result pending
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    // a parked result waits untouched while the consumer stalls
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid slot lost or changed during stall");

    // state changes only on an accepted request
    a_state_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("cpu state moved without a request");

endmodule
